FILE: sv/rqs_pkg.sv
// Shared constants for the randomized quicksort engine.
`timescale 1ns / 1ps
package rqs_pkg;
  localparam int unsigned DEPTH       = 64;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned IDX_W       = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W       = IDX_W + 1;
  localparam int unsigned STACK_DEPTH = DEPTH;
  localparam int unsigned LFSR_W      = 16;
  localparam int unsigned STEP_W      = $clog2(LFSR_W);
  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
  localparam logic [LFSR_W-1:0] LFSR_MASK = 16'hB400;
endpackage

FILE: sv/randomized_quicksort_engine.sv
// Top level of the randomized quicksort engine: element store, range stack and sort sequencer.
`timescale 1ns / 1ps
// Words arrive on the s_axis channel, one signed element each, and are written into a
// 64-entry element store. A word with tlast set closes the set and starts the sort; words
// beyond the store depth are dropped and flagged. The store takes one word per cycle while idle.
// The sort is an in-place quicksort on one single-port store with a separate range stack.
// Each partition pops a range from the stack, runs the bit-serial remainder for the random
// pivot and swaps the pivot to the front, then scans the range and swaps every element below
// the pivot into the lower part; all element accesses share the single store port.
// The sorted run leaves on the m_axis channel, one word at a time while the receiver is ready,
// with tlast on the final word and tuser set when words were dropped.
// No new word is taken from the end of a set until the last sorted word has been loaded
// into the output register; a stalled receiver holds the sequencer in place.
// After reset the store is empty, the drop flag is clear and the pivot LFSR holds its seed.
module randomized_quicksort_engine
  import rqs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [DATA_W-1:0] s_axis_tdata,   // [31:0] item_value
  input  logic              s_axis_tlast,   // last_item
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [DATA_W-1:0] m_axis_tdata,   // [31:0] sorted_value
  output logic              m_axis_tlast,   // run_end
  output logic [0:0]        m_axis_tuser    // [0] overflowed
);
  typedef enum logic [4:0] {
    ST_IDLE, ST_INIT, ST_POP, ST_POPW, ST_DIV,
    ST_SW0, ST_SW1, ST_SW2, ST_SW3,
    ST_SCAN, ST_CMP, ST_PUSH1, ST_PUSH2,
    ST_ORD, ST_OLD
  } state_e;

  typedef enum logic [1:0] {SW_PIVOT, SW_PART, SW_FINAL} swap_e;

  localparam int unsigned SE_W = 2 * IDX_W;

  state_e state_q;
  swap_e  kind_q;

  logic [DATA_W-1:0] store_mem [DEPTH];
  logic [SE_W-1:0]   stack_mem [STACK_DEPTH];

  logic [CNT_W-1:0]  fill_q;
  logic              drop_q;
  logic [CNT_W-1:0]  sp_q;
  logic [LFSR_W-1:0] lfsr_q;
  logic [LFSR_W-1:0] lfsr_d;
  logic [IDX_W-1:0]  lo_q, hi_q, mid_q, swx_q, swy_q;
  logic [CNT_W-1:0]  k_q;
  logic [CNT_W-1:0]  oidx_q;
  logic [DATA_W-1:0] pivot_q, hold_q, rdata_q;
  logic [SE_W-1:0]   srdata_q;
  logic              out_valid_q, out_last_q, out_drop_q;
  logic [DATA_W-1:0] out_data_q;

  logic              mem_we, mem_re;
  logic [IDX_W-1:0]  mem_addr;
  logic [DATA_W-1:0] mem_wdata;
  logic              stk_we, stk_re;
  logic [IDX_W-1:0]  stk_addr;
  logic [SE_W-1:0]   stk_wdata;

  logic [IDX_W-1:0]  pop_lo, pop_hi;
  logic              in_acc, out_acc;
  logic              rem_start, rem_done;
  logic [IDX_W-1:0]  rem_val;
  logic [CNT_W-1:0]  span;
  logic              push1_ok, push2_ok, is_less, stk_room;

  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign out_acc   = m_axis_tvalid && m_axis_tready;
  assign pop_lo    = srdata_q[IDX_W-1:0];
  assign pop_hi    = srdata_q[SE_W-1:IDX_W];
  assign lfsr_d    = (lfsr_q >> 1) ^ (lfsr_q[0] ? LFSR_MASK : '0);
  assign span      = CNT_W'(pop_hi) - CNT_W'(pop_lo) + 1'b1;
  assign rem_start = (state_q == ST_POPW) && (pop_lo < pop_hi);
  assign push1_ok  = (CNT_W'(mid_q) + 1'b1) < CNT_W'(hi_q);
  assign push2_ok  = CNT_W'(mid_q) > (CNT_W'(lo_q) + 1'b1);
  assign is_less   = $signed(rdata_q) < $signed(pivot_q);
  assign stk_room  = sp_q < CNT_W'(STACK_DEPTH);

  rqs_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (lfsr_d),
    .divisor_i  (span),
    .done_o     (rem_done),
    .rem_o      (rem_val)
  );

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = '0;
    mem_wdata = s_axis_tdata;
    stk_we    = 1'b0;
    stk_re    = 1'b0;
    stk_addr  = sp_q[IDX_W-1:0];
    stk_wdata = '0;
    case (state_q)
      ST_IDLE: begin
        mem_we   = in_acc && (fill_q < CNT_W'(DEPTH));
        mem_addr = fill_q[IDX_W-1:0];
      end
      ST_INIT: begin
        stk_we    = fill_q >= CNT_W'(2);
        stk_addr  = '0;
        stk_wdata = {IDX_W'(fill_q - 1'b1), IDX_W'(0)};
      end
      ST_POP: begin
        stk_re   = sp_q != '0;
        stk_addr = IDX_W'(sp_q - 1'b1);
      end
      ST_SW0: begin
        mem_re   = 1'b1;
        mem_addr = swx_q;
      end
      ST_SW1: begin
        mem_re   = 1'b1;
        mem_addr = swy_q;
      end
      ST_SW2: begin
        mem_we    = 1'b1;
        mem_addr  = swx_q;
        mem_wdata = rdata_q;
      end
      ST_SW3: begin
        mem_we    = 1'b1;
        mem_addr  = swy_q;
        mem_wdata = hold_q;
      end
      ST_SCAN: begin
        mem_re   = k_q <= CNT_W'(hi_q);
        mem_addr = k_q[IDX_W-1:0];
      end
      ST_PUSH1: begin
        stk_we    = push1_ok && stk_room;
        stk_wdata = {hi_q, IDX_W'(mid_q + 1'b1)};
      end
      ST_PUSH2: begin
        stk_we    = push2_ok && stk_room;
        stk_wdata = {IDX_W'(mid_q - 1'b1), lo_q};
      end
      ST_ORD: begin
        mem_re   = !out_valid_q;
        mem_addr = oidx_q[IDX_W-1:0];
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[mem_addr] <= mem_wdata;
    end else if (mem_re) begin
      rdata_q <= store_mem[mem_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stack_mem[stk_addr] <= stk_wdata;
    end else if (stk_re) begin
      srdata_q <= stack_mem[stk_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      kind_q      <= SW_PIVOT;
      fill_q      <= '0;
      drop_q      <= 1'b0;
      sp_q        <= '0;
      lfsr_q      <= LFSR_SEED;
      out_valid_q <= 1'b0;
    end else begin
      if (out_acc) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (fill_q < CNT_W'(DEPTH)) begin
              fill_q <= fill_q + 1'b1;
            end else begin
              drop_q <= 1'b1;
            end
            if (s_axis_tlast) begin
              state_q <= ST_INIT;
            end
          end
        end
        ST_INIT: begin
          oidx_q <= '0;
          if (fill_q >= CNT_W'(2)) begin
            sp_q    <= CNT_W'(1);
            state_q <= ST_POP;
          end else begin
            sp_q    <= '0;
            state_q <= ST_ORD;
          end
        end
        ST_POP: begin
          if (sp_q == '0) begin
            oidx_q  <= '0;
            state_q <= ST_ORD;
          end else begin
            sp_q    <= sp_q - 1'b1;
            state_q <= ST_POPW;
          end
        end
        ST_POPW: begin
          lo_q <= pop_lo;
          hi_q <= pop_hi;
          if (pop_lo < pop_hi) begin
            lfsr_q  <= lfsr_d;
            state_q <= ST_DIV;
          end else begin
            state_q <= ST_POP;
          end
        end
        ST_DIV: begin
          if (rem_done) begin
            swx_q   <= lo_q;
            swy_q   <= lo_q + rem_val;
            kind_q  <= SW_PIVOT;
            state_q <= ST_SW0;
          end
        end
        ST_SW0: begin
          state_q <= ST_SW1;
        end
        ST_SW1: begin
          hold_q  <= rdata_q;
          state_q <= ST_SW2;
        end
        ST_SW2: begin
          if (kind_q == SW_PIVOT) begin
            pivot_q <= rdata_q;
          end
          state_q <= ST_SW3;
        end
        ST_SW3: begin
          case (kind_q)
            SW_PIVOT: begin
              mid_q   <= lo_q;
              k_q     <= CNT_W'(lo_q) + 1'b1;
              state_q <= ST_SCAN;
            end
            SW_PART: begin
              k_q     <= k_q + 1'b1;
              state_q <= ST_SCAN;
            end
            default: begin
              state_q <= ST_PUSH1;
            end
          endcase
        end
        ST_SCAN: begin
          if (k_q > CNT_W'(hi_q)) begin
            swx_q   <= mid_q;
            swy_q   <= lo_q;
            kind_q  <= SW_FINAL;
            state_q <= ST_SW0;
          end else begin
            state_q <= ST_CMP;
          end
        end
        ST_CMP: begin
          if (is_less) begin
            mid_q   <= mid_q + 1'b1;
            swx_q   <= mid_q + 1'b1;
            swy_q   <= k_q[IDX_W-1:0];
            kind_q  <= SW_PART;
            state_q <= ST_SW0;
          end else begin
            k_q     <= k_q + 1'b1;
            state_q <= ST_SCAN;
          end
        end
        ST_PUSH1: begin
          if (push1_ok && stk_room) begin
            sp_q <= sp_q + 1'b1;
          end
          state_q <= ST_PUSH2;
        end
        ST_PUSH2: begin
          if (push2_ok && stk_room) begin
            sp_q <= sp_q + 1'b1;
          end
          state_q <= ST_POP;
        end
        ST_ORD: begin
          if (!out_valid_q) begin
            state_q <= ST_OLD;
          end
        end
        ST_OLD: begin
          out_valid_q <= 1'b1;
          out_data_q  <= rdata_q;
          out_drop_q  <= drop_q;
          out_last_q  <= (oidx_q + 1'b1) == fill_q;
          if ((oidx_q + 1'b1) == fill_q) begin
            fill_q  <= '0;
            drop_q  <= 1'b0;
            state_q <= ST_IDLE;
          end else begin
            oidx_q  <= oidx_q + 1'b1;
            state_q <= ST_ORD;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready   = state_q == ST_IDLE;
  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tlast    = out_last_q;
  assign m_axis_tuser[0] = out_drop_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q <= CNT_W'(DEPTH)) && (sp_q <= CNT_W'(STACK_DEPTH)))
    else $error("fill count or stack pointer out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN || state_q == ST_CMP) |-> (k_q > CNT_W'(mid_q)))
    else $error("partition boundary passed the scan index");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (lo_q < hi_q))
    else $error("partition started on a range of fewer than two elements");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OLD) |=> m_axis_tvalid)
    else $error("sorted word was not presented after loading");
endmodule

FILE: sv/rqs_rem.sv
// Bit-serial remainder unit that reduces the pivot random word modulo the range span.
`timescale 1ns / 1ps
module rqs_rem
  import rqs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [LFSR_W-1:0] dividend_i,
  input  logic [CNT_W-1:0]  divisor_i,
  output logic              done_o,
  output logic [IDX_W-1:0]  rem_o
);
  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] cnt_q;
  logic [LFSR_W-1:0] dvd_q;
  logic [CNT_W-1:0]  div_q;
  logic [CNT_W-1:0]  rem_q;
  logic [CNT_W-1:0]  trial_d;
  logic [CNT_W-1:0]  rem_d;

  assign trial_d = {rem_q[CNT_W-2:0], dvd_q[LFSR_W-1]};
  assign rem_d   = (trial_d >= div_q) ? (trial_d - div_q) : trial_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == STEP_W'(LFSR_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[LFSR_W-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[IDX_W-1:0];
endmodule

FILE: tb/randomized_quicksort_engine_test.sv
// Testbench for the randomized quicksort engine: streams sets of words and checks each sorted run.
`timescale 1ns / 1ps
module randomized_quicksort_engine_test;
  import rqs_pkg::*;

  localparam int unsigned STALL_LIMIT = 200000;
  localparam int unsigned SETTLE_CYCLES = 200;
  localparam int unsigned HOLD_CYCLES = 400;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              run_end;
    logic              overflowed;
  } sorted_word_t;

  class sort_scoreboard;
    int           set_values[$];
    bit           set_dropped;
    sorted_word_t pending_words[$];
    int           mismatch_count;

    task report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatch_count++;
    endtask

    function void note_word(input logic [DATA_W-1:0] value, input logic last);
      int           ordered[$];
      int           key;
      int           j;
      sorted_word_t word;
      if (set_values.size() < DEPTH) begin
        set_values.push_back($signed(value));
      end else begin
        set_dropped = 1'b1;
      end
      if (!last) return;
      ordered = set_values;
      for (int i = 1; i < ordered.size(); i++) begin
        key = ordered[i];
        j = i - 1;
        while (j >= 0 && ordered[j] > key) begin
          ordered[j + 1] = ordered[j];
          j--;
        end
        ordered[j + 1] = key;
      end
      foreach (ordered[i]) begin
        word.value = ordered[i];
        word.run_end = (i == ordered.size() - 1);
        word.overflowed = set_dropped;
        pending_words.push_back(word);
      end
      set_values.delete();
      set_dropped = 1'b0;
    endfunction

    task check_word(input logic [DATA_W-1:0] value, input logic run_end,
                    input logic overflowed);
      sorted_word_t want;
      if (pending_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word %h", value));
        return;
      end
      want = pending_words.pop_front();
      if (value !== want.value)
        report_mismatch($sformatf("value %h, wanted %h", value, want.value));
      if (run_end !== want.run_end)
        report_mismatch($sformatf("last flag %b, wanted %b", run_end, want.run_end));
      if (overflowed !== want.overflowed)
        report_mismatch($sformatf("drop flag %b, wanted %b", overflowed, want.overflowed));
    endtask
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [DATA_W-1:0] s_axis_tdata;
  logic              s_axis_tlast;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [DATA_W-1:0] m_axis_tdata;
  logic              m_axis_tlast;
  logic [0:0]        m_axis_tuser;

  sort_scoreboard board;
  int             items_sent;
  int             results_seen;
  int             stall_cycles;
  bit             calm;
  bit             hold_done;
  int             hold_left;

  randomized_quicksort_engine u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
  end

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        board.check_word(m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
        results_seen++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        board.note_word(s_axis_tdata, s_axis_tlast);
      end
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // The receiver stalls at random, and once for a long stretch after thirty words have been seen.
  initial begin
    m_axis_tready = 1'b0;
    hold_done = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (!hold_done && results_seen >= 30) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 16);
      end
    end
  end

  task automatic send_word(input logic [DATA_W-1:0] value, input logic last);
    @(negedge clk_i);
    while (!calm && $urandom_range(0, 99) < 16) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic drain_outputs();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (board.pending_words.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [DATA_W-1:0] pick_value(input int mode);
    case (mode)
      0: return $urandom;
      1: return 32'($urandom_range(0, 8)) - 32'd4;
      2: begin
        if ($urandom_range(0, 1) == 1) return 32'h7FFF_FFFF - 32'($urandom_range(0, 3));
        return 32'h8000_0000 + 32'($urandom_range(0, 3));
      end
      default: return {16'($urandom_range(0, 65535)), 16'($urandom)};
    endcase
  endfunction

  initial begin
    int size;
    int mode;
    board = new;
    items_sent = 0;
    results_seen = 0;
    stall_cycles = 0;
    calm = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // Single word at the low extreme, then the two extremes reversed.
    send_word(32'h8000_0000, 1'b1);
    send_word(32'h7FFF_FFFF, 1'b0);
    send_word(32'h8000_0000, 1'b1);
    // Values around zero with a duplicate, and both extremes.
    send_word(32'h0000_0000, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'h0000_0001, 1'b0);
    send_word(32'h7FFF_FFFF, 1'b0);
    send_word(32'h8000_0000, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b1);
    for (int k = 0; k < 6; k++) send_word(32'(50 - 20 * k), k == 5);
    for (int k = 0; k < 4; k++) send_word(32'h5A5A_A5A5, k == 3);

    // Set 4 ends with a dropped last word; set 12 drops its last four words.
    for (int set_no = 0; items_sent < 180 || set_no <= 12; set_no++) begin
      calm = (set_no >= 6 && set_no <= 9);
      if (set_no == 3) drain_outputs();
      if (set_no == 4) begin
        size = DEPTH + 1;
      end else if (set_no == 12) begin
        size = DEPTH + 4;
      end else begin
        size = $urandom_range(1, 6);
      end
      mode = $urandom_range(0, 3);
      for (int k = 0; k < size; k++) send_word(pick_value(mode), k == size - 1);
    end
    calm = 1'b0;

    drain_outputs();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (board.mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
